/* src/tlbpt_pkg.sv */
// Shared widths, constants and a helper function of the TLB page-table translator.
`timescale 1ns / 1ps
package tlbpt_pkg;

	// Fixed widths of the request and response fields.
	localparam int ADDR_W  = 16;
	localparam int COUNT_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Saturating increment of an event counter.
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

/* src/tlbpt_req_if.sv */
// Request channel: one logical address per request.
`timescale 1ns / 1ps
interface tlbpt_req_if;
	logic                            valid;
	logic                            ready;
	logic [tlbpt_pkg::ADDR_W-1:0]    logical_address;

	modport source (output valid, output logical_address, input ready);
	modport sink   (input valid, input logical_address, output ready);
endinterface

/* src/tlbpt_rsp_if.sv */
// Response channel: translated address, lookup flags and running counts.
`timescale 1ns / 1ps
interface tlbpt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [tlbpt_pkg::ADDR_W-1:0]    physical_address;
	logic                            tlb_hit;
	logic                            page_fault;
	logic [tlbpt_pkg::COUNT_W-1:0]   hits_so_far;
	logic [tlbpt_pkg::COUNT_W-1:0]   misses_so_far;
	logic [tlbpt_pkg::COUNT_W-1:0]   faults_so_far;

	modport source (output valid, output physical_address, output tlb_hit, output page_fault,
		output hits_so_far, output misses_so_far, output faults_so_far, input ready);
	modport sink   (input valid, input physical_address, input tlb_hit, input page_fault,
		input hits_so_far, input misses_so_far, input faults_so_far, output ready);
endinterface

/* src/tlb_page_table_translator.sv */
// Top level: address translator with a FIFO-replaced TLB and a demand-paged page table.
`timescale 1ns / 1ps
// Usage
// The block takes one logical address per request on the req channel and returns one
// response per request on the rsp channel, in order. Both channels use a valid/ready
// handshake; a request moves at a rising edge where valid and ready are both high.
// The address is split into a page number (upper bits, taken modulo PAGE_COUNT) and an
// offset (low OFFSET_BITS bits). The page is compared against all TLB entries at once;
// on a miss the page-table entry read from the page-table memory supplies the frame, or
// a new frame is assigned in ascending order when the entry is empty (a page fault).
// Every miss writes the translation into the TLB slot named by a FIFO victim pointer.
// Flow: a request accepted in the idle state moves the block to the lookup state, where
// the page-table entry read at acceptance is registered; the response is registered in
// the output register when the lookup finishes and is offered from then on. The block
// takes no new request until the lookup of the last one has finished.
// Reset: arst_n clears the TLB valid bits, the victim pointer, the free-frame pointer and
// all counters, then the block sweeps the page-table memory to invalid, one entry per
// cycle, until every entry is cleared. req.ready stays low during the sweep.
// Stalls: the response sits in an output register. If it has not been taken when the
// next request finishes its lookup, that request waits in the lookup stage, with no
// state committed, until the output register frees up.
module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = 16,
	parameter int PAGE_COUNT  = 256,
	parameter int OFFSET_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	tlbpt_req_if.sink   req,
	tlbpt_rsp_if.source rsp
);

	localparam int ADDR_W    = tlbpt_pkg::ADDR_W;
	localparam int COUNT_W   = tlbpt_pkg::COUNT_W;
	localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int PAGE_W    = $clog2(PAGE_COUNT);
	// Frame numbers run 0..PAGE_COUNT-1; the free pointer also needs to hold PAGE_COUNT.
	localparam int FRAME_W   = $clog2(PAGE_COUNT + 1);
	localparam int RAW_W     = (ADDR_W > OFFSET_BITS) ? (ADDR_W - OFFSET_BITS) : 1;
	localparam int WIDE_W    = ADDR_W + FRAME_W;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} state_t;

	// Reduce the raw page number modulo PAGE_COUNT by restoring subtraction of
	// shifted copies of the constant.
	function automatic logic [PAGE_W-1:0] page_mod(input logic [RAW_W-1:0] raw);
		logic [31:0] v;
		v = 32'(raw);
		for (int k = RAW_W - 1; k >= 0; k--) begin
			if (v >= (32'(PAGE_COUNT) << k)) begin
				v = v - (32'(PAGE_COUNT) << k);
			end
		end
		return v[PAGE_W-1:0];
	endfunction

	state_t state_q;

	// Page-table memory: valid bit on top of the frame number.
	logic [FRAME_W:0]   pt_mem [PAGE_COUNT];
	logic [FRAME_W:0]   pt_rdata_q;
	logic               pt_we;
	logic [PAGE_W-1:0]  pt_waddr;
	logic [FRAME_W:0]   pt_wdata;
	logic [PAGE_W-1:0]  clr_idx_q;

	// TLB: tags and frames are payload; the valid bits are cleared at reset.
	logic [PAGE_W-1:0]  tlb_tag_q   [TLB_ENTRIES];
	logic [FRAME_W-1:0] tlb_frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	logic [TLB_IDX_W-1:0]   victim_q;

	logic [FRAME_W-1:0] next_free_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic [COUNT_W-1:0] miss_cnt_q;
	logic [COUNT_W-1:0] fault_cnt_q;

	// Request held in the lookup stage.
	logic [PAGE_W-1:0]      page_s1;
	logic [OFFSET_BITS-1:0] offset_s1;

	// Output register.
	logic                   out_valid_q;
	logic [ADDR_W-1:0]      phys_q;
	logic                   hit_q;
	logic                   fault_q;
	logic [COUNT_W-1:0]     hits_out_q;
	logic [COUNT_W-1:0]     misses_out_q;
	logic [COUNT_W-1:0]     faults_out_q;

	logic                   req_fire;
	logic [RAW_W-1:0]       raw_page;
	logic [PAGE_W-1:0]      req_page;
	logic                   lk_hit;
	logic [FRAME_W-1:0]     lk_hit_frame;
	logic                   lk_fault;
	logic [FRAME_W-1:0]     lk_frame;
	logic [WIDE_W-1:0]      lk_wide;
	logic                   finish;
	logic [COUNT_W-1:0]     hit_cnt_nxt;
	logic [COUNT_W-1:0]     miss_cnt_nxt;
	logic [COUNT_W-1:0]     fault_cnt_nxt;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign raw_page  = RAW_W'({1'b0, req.logical_address} >> OFFSET_BITS);
	assign req_page  = page_mod(raw_page);

	// Fully associative compare; the first matching valid slot wins.
	always_comb begin
		lk_hit       = 1'b0;
		lk_hit_frame = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (!lk_hit && tlb_valid_q[i] && (tlb_tag_q[i] == page_s1)) begin
				lk_hit       = 1'b1;
				lk_hit_frame = tlb_frame_q[i];
			end
		end
	end

	// An empty page-table entry on a TLB miss takes the next free frame.
	assign lk_fault = !lk_hit && !pt_rdata_q[FRAME_W];
	assign lk_frame = lk_hit ? lk_hit_frame :
		(lk_fault ? next_free_q : pt_rdata_q[FRAME_W-1:0]);
	assign lk_wide  = (WIDE_W'(lk_frame) << OFFSET_BITS) | WIDE_W'(offset_s1);

	// The lookup commits only when the output register can take its response.
	assign finish = (state_q == ST_LOOKUP) && (!out_valid_q || rsp.ready);

	assign hit_cnt_nxt   = lk_hit   ? tlbpt_pkg::sat_inc(hit_cnt_q)   : hit_cnt_q;
	assign miss_cnt_nxt  = !lk_hit  ? tlbpt_pkg::sat_inc(miss_cnt_q)  : miss_cnt_q;
	assign fault_cnt_nxt = lk_fault ? tlbpt_pkg::sat_inc(fault_cnt_q) : fault_cnt_q;

	// Page-table write port: the reset sweep, or a new mapping on a fault.
	always_comb begin
		pt_we    = 1'b0;
		pt_waddr = page_s1;
		pt_wdata = {1'b1, next_free_q};
		if (state_q == ST_CLEAR) begin
			pt_we    = 1'b1;
			pt_waddr = clr_idx_q;
			pt_wdata = '0;
		end else if (finish && lk_fault) begin
			pt_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
		if (req_fire) begin
			pt_rdata_q <= pt_mem[req_page];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			tlb_valid_q <= '0;
			victim_q    <= '0;
			next_free_q <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			fault_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == PAGE_W'(PAGE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase

			if (finish) begin
				hit_cnt_q   <= hit_cnt_nxt;
				miss_cnt_q  <= miss_cnt_nxt;
				fault_cnt_q <= fault_cnt_nxt;
				if (lk_fault && (next_free_q != FRAME_W'(PAGE_COUNT))) begin
					next_free_q <= next_free_q + 1'b1;
				end
				if (!lk_hit) begin
					tlb_valid_q[victim_q] <= 1'b1;
					victim_q <= (victim_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
						'0 : victim_q + 1'b1;
				end
			end

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			page_s1   <= req_page;
			offset_s1 <= req.logical_address[OFFSET_BITS-1:0];
		end
		if (finish) begin
			if (!lk_hit) begin
				tlb_tag_q[victim_q]   <= page_s1;
				tlb_frame_q[victim_q] <= lk_frame;
			end
			phys_q       <= lk_wide[ADDR_W-1:0];
			hit_q        <= lk_hit;
			fault_q      <= lk_fault;
			hits_out_q   <= hit_cnt_nxt;
			misses_out_q <= miss_cnt_nxt;
			faults_out_q <= fault_cnt_nxt;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.physical_address = phys_q;
	assign rsp.tlb_hit          = hit_q;
	assign rsp.page_fault       = fault_q;
	assign rsp.hits_so_far      = hits_out_q;
	assign rsp.misses_so_far    = misses_out_q;
	assign rsp.faults_so_far    = faults_out_q;

endmodule

/* src/tlbpt_checker.sv */
// Port-level checker for the TLB page-table translator and its bind statement.
`timescale 1ns / 1ps
module tlbpt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [tlbpt_pkg::ADDR_W-1:0]  physical_address,
	input logic                          tlb_hit,
	input logic                          page_fault,
	input logic [tlbpt_pkg::COUNT_W-1:0] hits_so_far,
	input logic [tlbpt_pkg::COUNT_W-1:0] misses_so_far,
	input logic [tlbpt_pkg::COUNT_W-1:0] faults_so_far
);

	// A stalled response keeps its address and its running counts.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(physical_address)
			&& $stable(hits_so_far) && $stable(misses_so_far) && $stable(faults_so_far))
		else $error("response changed while stalled");

	// A fault can only come from a TLB miss.
	a_fault_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(tlb_hit && page_fault))
		else $error("page fault reported on a TLB hit");

	// The running count matching this response's outcome includes it.
	a_counts_include: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!tlb_hit || hits_so_far != '0) && (tlb_hit || misses_so_far != '0)
			&& (!page_fault || faults_so_far != '0))
		else $error("running count misses the current response");

	// Every fault is also a miss, so the fault count never passes the miss count.
	a_faults_le_misses: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> faults_so_far <= misses_so_far)
		else $error("fault count exceeds miss count");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.physical_address (rsp.physical_address),
	.tlb_hit          (rsp.tlb_hit),
	.page_fault       (rsp.page_fault),
	.hits_so_far      (rsp.hits_so_far),
	.misses_so_far    (rsp.misses_so_far),
	.faults_so_far    (rsp.faults_so_far)
);

/* dv/testbench.sv */
// Self-checking testbench for the TLB page-table translator: directed table plus random traffic.
`timescale 1ns / 1ps
module testbench;

	localparam int ADDR_W  = tlbpt_pkg::ADDR_W;
	localparam int COUNT_W = tlbpt_pkg::COUNT_W;
	localparam logic [COUNT_W-1:0] COUNT_MAX = tlbpt_pkg::COUNT_MAX;

	// Geometry of the block under test; these match the defaults of the RTL.
	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_COUNT  = 256;
	localparam int OFFSET_BITS = 8;

	localparam int DIRECTED_COUNT   = 24;
	localparam int RANDOM_COUNT     = 700;
	localparam int LONG_HOLD_AT     = 200;
	localparam int DRAIN_PAUSE_AT   = 420;
	localparam int QUIET_FROM       = 600;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int WORKING_PAGES    = 24;
	localparam int RECENT_PAGES     = 8;
	localparam int MAX_REPORTS      = 10;

	// One response as it appears on the response channel.
	typedef struct packed {
		logic [ADDR_W-1:0]  physical_address;
		logic               tlb_hit;
		logic               page_fault;
		logic [COUNT_W-1:0] hits_so_far;
		logic [COUNT_W-1:0] misses_so_far;
		logic [COUNT_W-1:0] faults_so_far;
	} translation_t;

	// A response still owed by the block, tagged with the address that caused it.
	typedef struct {
		logic [ADDR_W-1:0] logical_address;
		translation_t      result;
	} owed_translation_t;

	// A row of the directed table. Where typed_in is set, the expected response is
	// written out by hand and replaces the prediction.
	typedef struct packed {
		logic [ADDR_W-1:0] logical_address;
		logic              typed_in;
		translation_t      expected;
	} directed_row_t;

	logic clk;
	logic arst_n;

	tlbpt_req_if req_ch ();
	tlbpt_rsp_if rsp_ch ();

	tlb_page_table_translator #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.PAGE_COUNT  (PAGE_COUNT),
		.OFFSET_BITS (OFFSET_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the translator state, advanced once per accepted request.
	bit                 shadow_pt_valid [PAGE_COUNT];
	bit [8:0]           shadow_pt_frame [PAGE_COUNT];
	bit [7:0]           shadow_tlb_tag [TLB_ENTRIES];
	bit [7:0]           shadow_tlb_frame [TLB_ENTRIES];
	bit                 shadow_tlb_valid [TLB_ENTRIES];
	int unsigned        shadow_victim;
	bit [8:0]           shadow_next_frame;
	bit [COUNT_W-1:0]   shadow_hits;
	bit [COUNT_W-1:0]   shadow_misses;
	bit [COUNT_W-1:0]   shadow_faults;

	owed_translation_t  owed_translations [$];
	int                 mismatch_count;

	// Handshake between the stimulus thread and the response-side ready driver.
	bit                 long_hold_request;
	bit                 quiet_phase;

	// Random traffic draws pages from a working set slightly larger than the TLB, so
	// that evicted pages come back as misses that find a valid page-table entry.
	logic [7:0]         working_set [WORKING_PAGES];
	logic [7:0]         recent_pages [RECENT_PAGES];
	int                 recent_slot;

	// Directed part. The first rows start from an empty TLB and page table, so their
	// responses can be typed in. Pages 1 through 15 then fill the TLB and wrap the
	// FIFO pointer, evicting page 0 and, one step later, page 255; both come back as
	// misses that do not fault.
	directed_row_t directed_rows [DIRECTED_COUNT] = '{
		'{16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1, 32'd0, 32'd1, 32'd1}},
		'{16'hFFFF, 1'b1, '{16'h01FF, 1'b0, 1'b1, 32'd0, 32'd2, 32'd2}},
		'{16'h00AB, 1'b1, '{16'h00AB, 1'b1, 1'b0, 32'd1, 32'd2, 32'd2}},
		'{16'hFF00, 1'b1, '{16'h0100, 1'b1, 1'b0, 32'd2, 32'd2, 32'd2}},
		'{16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 32'd3, 32'd2, 32'd2}},
		'{16'h0155, 1'b0, '0},
		'{16'h02AA, 1'b0, '0},
		'{16'h0355, 1'b0, '0},
		'{16'h04AA, 1'b0, '0},
		'{16'h0555, 1'b0, '0},
		'{16'h06AA, 1'b0, '0},
		'{16'h0755, 1'b0, '0},
		'{16'h08AA, 1'b0, '0},
		'{16'h0955, 1'b0, '0},
		'{16'h0AAA, 1'b0, '0},
		'{16'h0B55, 1'b0, '0},
		'{16'h0CAA, 1'b0, '0},
		'{16'h0D55, 1'b0, '0},
		'{16'h0EAA, 1'b0, '0},
		'{16'h0F55, 1'b0, '0},
		'{16'h0042, 1'b1, '{16'h0042, 1'b0, 1'b0, 32'd3, 32'd18, 32'd17}},
		'{16'hFF80, 1'b1, '{16'h0180, 1'b0, 1'b0, 32'd3, 32'd19, 32'd17}},
		'{16'h8000, 1'b0, '0},
		'{16'h7F7F, 1'b0, '0}
	};

	// Translates one logical address and advances the shadow state: TLB compare first,
	// then the page table on a miss, with a fresh frame when the entry is empty.
	function automatic translation_t translate_address(input logic [ADDR_W-1:0] addr);
		translation_t res;
		int unsigned  page;
		int unsigned  offset;
		int unsigned  frame;
		int unsigned  slot;
		bit           found;
		bit           faulted;
		logic [31:0]  wide_addr;

		offset  = 32'(addr[OFFSET_BITS-1:0]);
		page    = 32'(addr[ADDR_W-1:OFFSET_BITS]) % PAGE_COUNT;
		frame   = 0;
		found   = 1'b0;
		faulted = 1'b0;

		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (!found && shadow_tlb_valid[i] && 32'(shadow_tlb_tag[i]) == page) begin
				frame = 32'(shadow_tlb_frame[i]);
				found = 1'b1;
			end
		end

		if (found) begin
			if (shadow_hits != COUNT_MAX)
				shadow_hits = shadow_hits + 1'b1;
		end else begin
			if (shadow_misses != COUNT_MAX)
				shadow_misses = shadow_misses + 1'b1;
			if (!shadow_pt_valid[page]) begin
				faulted = 1'b1;
				if (shadow_faults != COUNT_MAX)
					shadow_faults = shadow_faults + 1'b1;
				shadow_pt_valid[page] = 1'b1;
				shadow_pt_frame[page] = shadow_next_frame;
				if (shadow_next_frame < 9'(PAGE_COUNT))
					shadow_next_frame = shadow_next_frame + 1'b1;
			end
			frame = 32'(shadow_pt_frame[page]);
			slot = shadow_victim % TLB_ENTRIES;
			shadow_tlb_tag[slot]   = page[7:0];
			shadow_tlb_frame[slot] = frame[7:0];
			shadow_tlb_valid[slot] = 1'b1;
			shadow_victim = (slot + 1) % TLB_ENTRIES;
		end

		// Frames wider than the address field lose their upper bits.
		wide_addr = (frame << OFFSET_BITS) | offset;
		res.physical_address = wide_addr[ADDR_W-1:0];
		res.tlb_hit          = found;
		res.page_fault       = faulted;
		res.hits_so_far      = shadow_hits;
		res.misses_so_far    = shadow_misses;
		res.faults_so_far    = shadow_faults;
		return res;
	endfunction

	// Picks a random address: mostly pages from the working set or recently used pages,
	// which exercise hits and refills from the page table, the rest fully random.
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned roll;
		logic [7:0]  page;

		roll = $urandom_range(0, 99);
		if (roll < 35)
			page = working_set[$urandom_range(0, WORKING_PAGES - 1)];
		else if (roll < 60)
			page = recent_pages[$urandom_range(0, RECENT_PAGES - 1)];
		else
			page = 8'($urandom_range(0, 255));
		return {page, 8'($urandom_range(0, 255))};
	endfunction

	function automatic void note_mismatch(input string what);
		if (mismatch_count < MAX_REPORTS)
			$display("[%0t] %s", $realtime, what);
		mismatch_count++;
	endfunction

	// Offers one request and holds it until the block takes it. A typed-in response,
	// when given, replaces the prediction but the shadow state still advances.
	task automatic send_request(input logic [ADDR_W-1:0] addr, input bit typed_in,
		input translation_t typed_result);
		owed_translation_t owed;
		translation_t      predicted;

		@(negedge clk);
		req_ch.valid           <= 1'b1;
		req_ch.logical_address <= addr;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = translate_address(addr);
		owed.logical_address = addr;
		owed.result = typed_in ? typed_result : predicted;
		owed_translations.push_back(owed);
	endtask

	// Drops valid for the given number of cycles.
	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net in case the block hangs; far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("tlb_page_table_translator verification failed");
		$finish;
	end

	// Response-side ready: random stall bursts, calm stretches with no stalls, one long
	// hold-off on request, and always ready once the quiet phase begins.
	initial begin
		int unsigned stall_left;
		int unsigned calm_left;
		int unsigned roll;

		stall_left = 0;
		calm_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet_phase) begin
				rsp_ch.ready <= 1'b1;
			end else if (long_hold_request) begin
				// Hold off long enough for both pipeline stages to fill and the
				// request side to stall.
				long_hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) begin
					@(negedge clk);
					rsp_ch.ready <= 1'b0;
				end
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				rsp_ch.ready <= 1'b1;
			end else begin
				roll = $urandom_range(0, 15);
				if (roll == 0) begin
					calm_left = $urandom_range(20, 60);
					rsp_ch.ready <= 1'b1;
				end else if (roll < 4) begin
					stall_left = $urandom_range(1, 11) - 1;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Response checker: every response taken must match the oldest one still owed.
	always @(posedge clk) begin
		translation_t      seen;
		owed_translation_t owed;

		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen.physical_address = rsp_ch.physical_address;
			seen.tlb_hit          = rsp_ch.tlb_hit;
			seen.page_fault       = rsp_ch.page_fault;
			seen.hits_so_far      = rsp_ch.hits_so_far;
			seen.misses_so_far    = rsp_ch.misses_so_far;
			seen.faults_so_far    = rsp_ch.faults_so_far;
			if (owed_translations.size() == 0) begin
				note_mismatch($sformatf("response with none owed: pa=%h hit=%b fault=%b",
					seen.physical_address, seen.tlb_hit, seen.page_fault));
			end else begin
				owed = owed_translations.pop_front();
				if (seen !== owed.result)
					note_mismatch($sformatf({"la=%h expected pa=%h hit=%b fault=%b ",
						"hits=%0d misses=%0d faults=%0d, got pa=%h hit=%b fault=%b ",
						"hits=%0d misses=%0d faults=%0d"},
						owed.logical_address, owed.result.physical_address,
						owed.result.tlb_hit, owed.result.page_fault,
						owed.result.hits_so_far, owed.result.misses_so_far,
						owed.result.faults_so_far, seen.physical_address, seen.tlb_hit,
						seen.page_fault, seen.hits_so_far, seen.misses_so_far,
						seen.faults_so_far));
			end
		end
	end

	// Main stimulus thread.
	initial begin
		logic [ADDR_W-1:0] addr;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.logical_address = '0;
		long_hold_request = 1'b0;
		quiet_phase = 1'b0;
		mismatch_count = 0;
		recent_slot = 0;
		shadow_victim = 0;
		shadow_next_frame = '0;
		shadow_hits = '0;
		shadow_misses = '0;
		shadow_faults = '0;
		for (int i = 0; i < PAGE_COUNT; i++) begin
			shadow_pt_valid[i] = 1'b0;
			shadow_pt_frame[i] = '0;
		end
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			shadow_tlb_tag[i] = '0;
			shadow_tlb_frame[i] = '0;
			shadow_tlb_valid[i] = 1'b0;
		end
		for (int i = 0; i < RECENT_PAGES; i++)
			recent_pages[i] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The page-table sweep after reset keeps req.ready low; the first handshake
		// simply waits it out.
		foreach (directed_rows[i])
			send_request(directed_rows[i].logical_address, directed_rows[i].typed_in,
				directed_rows[i].expected);

		for (int i = 0; i < WORKING_PAGES; i++)
			working_set[i] = 8'($urandom_range(0, 255));

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i == LONG_HOLD_AT) begin
				@(posedge clk);
				long_hold_request = 1'b1;
			end
			if (i == DRAIN_PAUSE_AT) begin
				// Let the block run completely dry before the next request.
				@(negedge clk);
				req_ch.valid <= 1'b0;
				while (owed_translations.size() != 0)
					@(negedge clk);
			end
			if (i == QUIET_FROM)
				quiet_phase = 1'b1;

			addr = pick_address();
			send_request(addr, 1'b0, '0);
			recent_pages[recent_slot] = addr[15:8];
			recent_slot = (recent_slot + 1) % RECENT_PAGES;

			// Sender gaps, except in every fourth block of fifty and in the quiet tail.
			if (!quiet_phase && (i / 50) % 4 != 3 && $urandom_range(0, 4) == 0)
				idle_sender($urandom_range(1, 11));
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (owed_translations.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && owed_translations.size() == 0)
			$display("tlb_page_table_translator verification clean");
		else
			$display("tlb_page_table_translator verification failed");
		$finish;
	end

endmodule

/* files.f */
src/tlbpt_pkg.sv
src/tlbpt_req_if.sv
src/tlbpt_rsp_if.sv
src/tlb_page_table_translator.sv
src/tlbpt_checker.sv
dv/testbench.sv
